// ===== hdl/matrix_multiply_bias_rows_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MATRIX_MULTIPLY_BIAS_ROWS_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_BIAS_ROWS_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MMBR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MMBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mmbr_pkg.sv =====
package mmbr_pkg;

   localparam int MODE_W     = 2;
   localparam int INDEX_W    = 8;
   localparam int COL_W      = 6;
   localparam int DATA_W     = 32;
   localparam int WEIGHT_W   = 16;
   localparam int ACC_W      = 40;
   localparam int PROD_W     = 32;
   localparam int LEN_W      = 9;
   localparam int CNT_W      = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 9;
   localparam int ROW_LIMIT  = 256;

   localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BIAS   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ACT    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_ENABLE  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [INDEX_W-1:0]        inner_index;
      logic [COL_W-1:0]          column_index;
      logic signed [DATA_W-1:0]  data_value;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]          out_column;
      logic signed [DATA_W-1:0]  out_value;
      logic                      last_of_row;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIAS_RD,
      ST_BIAS_WR,
      ST_ACC_RUN,
      ST_ACC_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             init;
      logic             bias_enable;
      logic             acc_valid;
      logic             last;
      logic [COL_W-1:0] col;
   } mac_issue_type;

   typedef struct packed {
      logic                    valid;
      logic                    last;
      logic [COL_W-1:0]        col;
      logic [DATA_W-1:0]       bias;
      logic signed [ACC_W-1:0] acc;
   } mac_wb_type;

endpackage

// ===== hdl/mmbr_ram.sv =====
module mmbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mmbr_mac.sv =====
module mmbr_mac (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mmbr_pkg::mac_issue_type                 issue,
   input  logic signed [mmbr_pkg::WEIGHT_W-1:0]    act,
   input  logic [mmbr_pkg::WEIGHT_W-1:0]           weight,
   input  logic [mmbr_pkg::DATA_W+mmbr_pkg::ACC_W-1:0] col_word,
   output mmbr_pkg::mac_wb_type                    wb
);

   mmbr_pkg::mac_issue_type s1_ff;

   logic                                 s2_valid_ff;
   logic                                 s2_last_ff;
   logic [mmbr_pkg::COL_W-1:0]           s2_col_ff;
   logic [mmbr_pkg::DATA_W-1:0]          s2_bias_ff;
   logic signed [mmbr_pkg::PROD_W-1:0]   prod_ff;
   logic signed [mmbr_pkg::ACC_W-1:0]    base_ff;

   logic signed [mmbr_pkg::WEIGHT_W-1:0] weight_s;
   logic [mmbr_pkg::DATA_W-1:0]          bias_word;
   logic signed [mmbr_pkg::DATA_W-1:0]   bias_s;
   logic signed [mmbr_pkg::ACC_W-1:0]    acc_word;
   logic signed [mmbr_pkg::PROD_W-1:0]   prod_in;
   logic signed [mmbr_pkg::ACC_W-1:0]    base_in;
   logic signed [mmbr_pkg::ACC_W:0]      sum;
   logic signed [mmbr_pkg::ACC_W-1:0]    sum_sat;

   assign weight_s  = $signed(weight);
   assign bias_word = col_word[mmbr_pkg::DATA_W+mmbr_pkg::ACC_W-1:mmbr_pkg::ACC_W];
   assign bias_s    = $signed(bias_word);
   assign acc_word  = $signed(col_word[mmbr_pkg::ACC_W-1:0]);
   assign prod_in   = mmbr_pkg::PROD_W'(act) * mmbr_pkg::PROD_W'(weight_s);

   always_comb begin
      if (s1_ff.init) begin
         base_in = s1_ff.bias_enable ? mmbr_pkg::ACC_W'(bias_s) : '0;
      end else begin
         base_in = s1_ff.acc_valid ? acc_word : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_ff       <= issue;
         s2_valid_ff <= s1_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_last_ff <= s1_ff.last;
      s2_col_ff  <= s1_ff.col;
      s2_bias_ff <= bias_word;
      prod_ff    <= prod_in;
      base_ff    <= base_in;
   end

   // saturate to the signed accumulator range
   always_comb begin
      sum = (mmbr_pkg::ACC_W+1)'(base_ff) + (mmbr_pkg::ACC_W+1)'(prod_ff);
      if (sum[mmbr_pkg::ACC_W] != sum[mmbr_pkg::ACC_W-1]) begin
         sum_sat = {sum[mmbr_pkg::ACC_W], {(mmbr_pkg::ACC_W-1){~sum[mmbr_pkg::ACC_W]}}};
      end else begin
         sum_sat = sum[mmbr_pkg::ACC_W-1:0];
      end
   end

   always_comb begin
      wb.valid = s2_valid_ff;
      wb.last  = s2_last_ff;
      wb.col   = s2_col_ff;
      wb.bias  = s2_bias_ff;
      wb.acc   = sum_sat;
   end

endmodule

// ===== hdl/matrix_multiply_bias_rows_unit.sv =====
// Matrix product with bias (pointwise convolution) in fixed point. Load weights with
// mode 0 and bias with mode 1 (a read-modify-write of the column memory), then stream
// activations with mode 2. Each activation runs one column per cycle through the shared
// multiply-accumulate unit, set by the single read port of the weight and column
// memories, and then waits for the two-stage unit to drain. The element at position
// inner_length - 1 then streams out one result per column; each column's read waits
// until the previous result has passed from the column memory's registered read into
// the output register, and a stalled output holds the stream. Activations are Q8.8,
// bias and results Q16.16; accumulation saturates at 40 bits and results at 32 bits.
// Weight and bias entries read before being written return undefined data; accumulators
// read as zero until first written. No clearing pass runs after reset.
module matrix_multiply_bias_rows_unit #(
   parameter int MAX_INNER   = 256,
   parameter int MAX_COLUMNS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mmbr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mmbr_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [mmbr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mmbr_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int ROWS      = (MAX_INNER < mmbr_pkg::ROW_LIMIT) ? MAX_INNER : mmbr_pkg::ROW_LIMIT;
   localparam int WDEPTH    = ROWS * MAX_COLUMNS;
   localparam int WAW       = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int CAW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int COLWORD_W = mmbr_pkg::DATA_W + mmbr_pkg::ACC_W;

   logic [mmbr_pkg::LEN_W-1:0]   inner_length_ff;
   logic [mmbr_pkg::CNT_W-1:0]   column_count_ff;
   logic                         bias_enable_ff;

   mmbr_pkg::state_type          state_ff, state_in;
   logic [mmbr_pkg::COL_W-1:0]   cnt_ff, cnt_in;
   logic [mmbr_pkg::INDEX_W-1:0] row_ff;
   logic [mmbr_pkg::COL_W-1:0]   item_col_ff;
   logic [mmbr_pkg::DATA_W-1:0]  data_ff;
   logic [MAX_COLUMNS-1:0]       acc_valid_ff;

   logic                         inflight_ff, inflight_in;
   logic [mmbr_pkg::COL_W-1:0]   emit_col_ff;
   logic                         emit_last_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   mmbr_pkg::rsp_type            rsp_data_ff;

   logic [mmbr_pkg::INDEX_W-1:0] last_row;
   logic [mmbr_pkg::COL_W-1:0]   last_col;
   logic                         accept;
   logic                         row_ok;
   logic                         col_ok;
   logic                         emit_rd;

   logic                         w_we;
   logic [WAW-1:0]               w_waddr;
   logic                         w_re;
   logic [WAW-1:0]               w_raddr;
   logic [mmbr_pkg::WEIGHT_W-1:0] w_rdata;

   logic                         c_we;
   logic [CAW-1:0]               c_waddr;
   logic [COLWORD_W-1:0]         c_wdata;
   logic                         c_re;
   logic [CAW-1:0]               c_raddr;
   logic [COLWORD_W-1:0]         c_rdata;
   logic                         bias_we;

   mmbr_pkg::mac_issue_type      issue;
   mmbr_pkg::mac_wb_type         wb;

   logic signed [mmbr_pkg::ACC_W-1:0]  emit_acc;
   logic signed [mmbr_pkg::DATA_W-1:0] emit_value;

   assign req_stall = (state_ff != mmbr_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign row_ok    = int'(req_data.inner_index) < MAX_INNER;
   assign col_ok    = int'(req_data.column_index) < MAX_COLUMNS;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_length_ff <= mmbr_pkg::LEN_W'(1);
         column_count_ff <= mmbr_pkg::CNT_W'(1);
         bias_enable_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mmbr_pkg::CSR_INNER_LENGTH: begin
               inner_length_ff <= csr_wr_data;
            end
            mmbr_pkg::CSR_COLUMN_COUNT: begin
               column_count_ff <= csr_wr_data[mmbr_pkg::CNT_W-1:0];
            end
            mmbr_pkg::CSR_BIAS_ENABLE: begin
               bias_enable_ff <= csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (inner_length_ff == '0) begin
         last_row = '0;
      end else if (inner_length_ff > mmbr_pkg::LEN_W'(ROWS)) begin
         last_row = mmbr_pkg::INDEX_W'(ROWS - 1);
      end else begin
         last_row = mmbr_pkg::INDEX_W'(inner_length_ff - mmbr_pkg::LEN_W'(1));
      end
      if (column_count_ff == '0) begin
         last_col = '0;
      end else if (column_count_ff > mmbr_pkg::CNT_W'(MAX_COLUMNS)) begin
         last_col = mmbr_pkg::COL_W'(MAX_COLUMNS - 1);
      end else begin
         last_col = mmbr_pkg::COL_W'(column_count_ff - mmbr_pkg::CNT_W'(1));
      end
   end

   assign w_we    = accept && (req_data.mode == mmbr_pkg::MODE_WEIGHT) && row_ok && col_ok;
   assign w_waddr = WAW'(int'(req_data.inner_index) * MAX_COLUMNS + int'(req_data.column_index));
   assign w_raddr = WAW'(int'(row_ff) * MAX_COLUMNS + int'(cnt_ff));

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      issue       = '0;
      w_re        = 1'b0;
      c_re        = 1'b0;
      c_raddr     = cnt_ff[CAW-1:0];
      bias_we     = 1'b0;
      emit_rd     = 1'b0;
      unique case (state_ff)
         mmbr_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  mmbr_pkg::MODE_BIAS: begin
                     if (col_ok) begin
                        state_in = mmbr_pkg::ST_BIAS_RD;
                     end
                  end
                  mmbr_pkg::MODE_ACT: begin
                     if (row_ok) begin
                        state_in = mmbr_pkg::ST_ACC_RUN;
                        cnt_in   = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mmbr_pkg::ST_BIAS_RD: begin
            c_re     = 1'b1;
            c_raddr  = item_col_ff[CAW-1:0];
            state_in = mmbr_pkg::ST_BIAS_WR;
         end
         mmbr_pkg::ST_BIAS_WR: begin
            bias_we  = 1'b1;
            state_in = mmbr_pkg::ST_IDLE;
         end
         mmbr_pkg::ST_ACC_RUN: begin
            c_re              = 1'b1;
            w_re              = 1'b1;
            issue.valid       = 1'b1;
            issue.init        = (row_ff == '0);
            issue.bias_enable = bias_enable_ff;
            issue.acc_valid   = acc_valid_ff[cnt_ff[CAW-1:0]];
            issue.last        = (cnt_ff == last_col);
            issue.col         = cnt_ff;
            if (cnt_ff == last_col) begin
               state_in = mmbr_pkg::ST_ACC_DRAIN;
            end else begin
               cnt_in = cnt_ff + mmbr_pkg::COL_W'(1);
            end
         end
         mmbr_pkg::ST_ACC_DRAIN: begin
            if (wb.valid && wb.last) begin
               if (row_ff == last_row) begin
                  state_in = mmbr_pkg::ST_EMIT;
                  cnt_in   = '0;
               end else begin
                  state_in = mmbr_pkg::ST_IDLE;
               end
            end
         end
         mmbr_pkg::ST_EMIT: begin
            if (!inflight_ff && (!rsp_valid_ff || !rsp_stall)) begin
               c_re    = 1'b1;
               emit_rd = 1'b1;
               if (cnt_ff == last_col) begin
                  state_in = mmbr_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + mmbr_pkg::COL_W'(1);
               end
            end
         end
         default: begin
            state_in = mmbr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmbr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (accept) begin
         row_ff      <= req_data.inner_index;
         item_col_ff <= req_data.column_index;
         data_ff     <= req_data.data_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= '0;
      end else if (wb.valid) begin
         acc_valid_ff[wb.col[CAW-1:0]] <= 1'b1;
      end
   end

   always_comb begin
      if (wb.valid) begin
         c_we    = 1'b1;
         c_waddr = wb.col[CAW-1:0];
         c_wdata = {wb.bias, wb.acc};
      end else begin
         c_we    = bias_we;
         c_waddr = item_col_ff[CAW-1:0];
         c_wdata = {data_ff, c_rdata[mmbr_pkg::ACC_W-1:0]};
      end
   end

   mmbr_ram #(
      .WIDTH (mmbr_pkg::WEIGHT_W),
      .DEPTH (WDEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (req_data.data_value[mmbr_pkg::WEIGHT_W-1:0]),
      .rd_en   (w_re),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   mmbr_ram #(
      .WIDTH (COLWORD_W),
      .DEPTH (MAX_COLUMNS)
   ) u_column_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_en   (c_re),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   mmbr_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .act      ($signed(data_ff[mmbr_pkg::WEIGHT_W-1:0])),
      .weight   (w_rdata),
      .col_word (c_rdata),
      .wb       (wb)
   );

   // clamp accumulator to the 32-bit result range
   always_comb begin
      emit_acc = $signed(c_rdata[mmbr_pkg::ACC_W-1:0]);
      if (emit_acc[mmbr_pkg::ACC_W-1:mmbr_pkg::DATA_W-1] != '0 &&
          emit_acc[mmbr_pkg::ACC_W-1:mmbr_pkg::DATA_W-1] != '1) begin
         emit_value = {emit_acc[mmbr_pkg::ACC_W-1],
                       {(mmbr_pkg::DATA_W-1){~emit_acc[mmbr_pkg::ACC_W-1]}}};
      end else begin
         emit_value = emit_acc[mmbr_pkg::DATA_W-1:0];
      end
   end

   always_comb begin
      inflight_in = emit_rd;
      if (inflight_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inflight_ff  <= inflight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_rd) begin
         emit_col_ff  <= cnt_ff;
         emit_last_ff <= (cnt_ff == last_col);
      end
      if (inflight_ff) begin
         rsp_data_ff.out_column  <= emit_col_ff;
         rsp_data_ff.out_value   <= emit_value;
         rsp_data_ff.last_of_row <= emit_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/mmbr_checker.sv =====
`include "matrix_multiply_bias_rows_unit_defines.svh"

module mmbr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input mmbr_pkg::rsp_type                     rsp_data
);

   logic                       rsp_xfer;
   logic                       mid_row_ff;
   logic [mmbr_pkg::COL_W-1:0] prev_col_ff;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   // track the column of the last transfer and whether its row is still open
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_row_ff  <= 1'b0;
         prev_col_ff <= '0;
      end else if (rsp_xfer) begin
         mid_row_ff  <= !rsp_data.last_of_row;
         prev_col_ff <= rsp_data.out_column;
      end
   end

   `MMBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `MMBR_ASSERT_SAME(a_idle_after_reset, clock, reset, $past(reset), !req_stall, "not idle after reset")
   `MMBR_ASSERT_SAME(a_busy_mid_row, clock, reset, rsp_valid && !rsp_data.last_of_row, req_stall, "input taken while a row is still streaming out")
   `MMBR_ASSERT_SAME(a_next_column, clock, reset, rsp_valid && mid_row_ff,
      rsp_data.out_column == prev_col_ff + mmbr_pkg::COL_W'(1), "row columns out of order")
   `MMBR_ASSERT_SAME(a_first_column, clock, reset, rsp_valid && !mid_row_ff,
      rsp_data.out_column == '0, "row does not start at column zero")

endmodule

bind matrix_multiply_bias_rows_unit mmbr_checker u_mmbr_checker (.*);
